// ===== hw/rtl/rtdct_pkg.sv =====
// Shared constants, widths and control types of the RTD code to temperature unit.
`timescale 1ns / 1ps

package rtdct_pkg;

    // Fixed-point fraction bits used throughout the datapath
    localparam int FRAC_BITS = 16;

    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 15;
    localparam int REF_W      = 14;
    localparam int NOM_W      = 10;
    localparam int TEMP_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Callendar-Van Dusen constants (c = 0), scaled by 2^FRAC_BITS, rounded
    localparam logic [63:0] CVD_C =
        ((64'd63944759600 << FRAC_BITS) + (64'd4851 >> 1)) / 64'd4851;
    localparam logic [63:0] CVD_P =
        ((64'd71060 << FRAC_BITS) + (64'd21 >> 1)) / 64'd21;

    // q*x = QX_NUM * code * ref / (QX_DEN * R0)
    localparam logic [63:0] QX_NUM = 64'd390625;
    localparam logic [63:0] QX_DEN = 64'd7392;

    localparam int QXN_W = $clog2(QX_NUM + 64'd1);
    localparam int QXD_W = $clog2(QX_DEN + 64'd1);
    localparam int C_W   = $clog2(CVD_C + 64'd1);
    localparam int P_W   = $clog2(CVD_P + 64'd1);

    localparam int P1_W   = CODE_W + REF_W;
    localparam int PROD_W = P1_W + QXN_W;
    localparam int DEN_W  = QXD_W + NOM_W;
    localparam int DVD_W  = PROD_W + FRAC_BITS;
    localparam int ROOT_W = (C_W + FRAC_BITS + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int SQR_W  = ROOT_W + 2;
    localparam int MAG_W  = (P_W > ROOT_W) ? P_W : ROOT_W;
    localparam int CENT_W = MAG_W + 7;
    localparam int CNT_W  = $clog2(DVD_W);

    localparam logic [BYTE_W-1:0] NO_REPLY    = 8'hFF;
    localparam logic [6:0]        CENTI_SCALE = 7'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_IDX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOM_IDX = 2'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // take input word, update held bytes, form code
        logic mul_code;   // code * ref
        logic mul_scale;  // times QX_NUM, set up divider
        logic div_step;   // one quotient bit
        logic root_init;  // range check, set up square root
        logic sqrt_step;  // one root bit
        logic mag;        // |P - S| and sign
        logic scale;      // times 100
        logic out_load;   // round and load output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic invalid;    // zero nominal resistance, later a negative discriminant
        logic qx_over;    // discriminant would be negative
    } sts_t;

endpackage

// ===== hw/rtl/rtdct_if.sv =====
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps

interface rtdct_in_if;
    logic                           valid;
    logic                           ready;
    logic [rtdct_pkg::BYTE_W-1:0]   msb_byte;
    logic [rtdct_pkg::BYTE_W-1:0]   lsb_byte;

    modport source (output valid, output msb_byte, output lsb_byte, input ready);
    modport sink   (input valid, input msb_byte, input lsb_byte, output ready);
endinterface

interface rtdct_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rtdct_pkg::TEMP_W-1:0]  temperature_centi;
    logic [rtdct_pkg::CODE_W-1:0]         adc_code;
    logic                                 root_invalid;

    modport source (output valid, output temperature_centi, output adc_code,
                    output root_invalid, input ready);
    modport sink   (input valid, input temperature_centi, input adc_code,
                    input root_invalid, output ready);
endinterface

// ===== hw/rtl/rtdct_ctrl.sv =====
// Sequencing state machine of the RTD code to temperature unit.
`timescale 1ns / 1ps

module rtdct_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rtdct_pkg::sts_t     sts,
    output rtdct_pkg::cmd_t     cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MUL1   = 9'b000000010,
        ST_MUL2   = 9'b000000100,
        ST_DIV    = 9'b000001000,
        ST_ROOT   = 9'b000010000,
        ST_SQRT   = 9'b000100000,
        ST_MAG    = 9'b001000000,
        ST_SCALE  = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [rtdct_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul_code = 1'b1;
                state_next   = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_scale = 1'b1;
                cnt_next      = rtdct_pkg::CNT_W'(rtdct_pkg::DVD_W - 1);
                state_next    = sts.invalid ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_init = 1'b1;
                cnt_next      = rtdct_pkg::CNT_W'(rtdct_pkg::ROOT_W - 1);
                state_next    = sts.qx_over ? ST_FINISH : ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait for the output register to drain
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_div_to_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0) |=> (state_reg == ST_ROOT))
        else $error("divider did not hand over to root stage");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MUL1))
        else $error("accepted word did not start the computation");
`endif

endmodule

// ===== hw/rtl/rtdct_dp.sv =====
// Datapath: held bytes, multipliers, bit-serial divider and square root, rounding.
`timescale 1ns / 1ps

module rtdct_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rtdct_pkg::cmd_t                      cmd,
    output rtdct_pkg::sts_t                      sts,
    input  logic [rtdct_pkg::BYTE_W-1:0]         msb_byte,
    input  logic [rtdct_pkg::BYTE_W-1:0]         lsb_byte,
    input  logic [rtdct_pkg::REF_W-1:0]          ref_ohms,
    input  logic [rtdct_pkg::NOM_W-1:0]          nom_ohms,
    output logic signed [rtdct_pkg::TEMP_W-1:0]  temperature_centi,
    output logic [rtdct_pkg::CODE_W-1:0]         adc_code,
    output logic                                 root_invalid
);

    localparam int F = rtdct_pkg::FRAC_BITS;
    localparam logic [rtdct_pkg::CENT_W:0] ROUND_HALF =
        (rtdct_pkg::CENT_W + 1)'(1) << (F - 1);

    // held bytes (control state, reset)
    logic [rtdct_pkg::BYTE_W-1:0] held_msb_reg, held_msb_next;
    logic [rtdct_pkg::BYTE_W-1:0] held_lsb_reg, held_lsb_next;

    // payload registers
    logic [rtdct_pkg::CODE_W-1:0]  code_reg;
    logic [rtdct_pkg::DEN_W-1:0]   den_reg;
    logic                          invalid_reg;
    logic [rtdct_pkg::P1_W-1:0]    p1_reg;
    logic [rtdct_pkg::DVD_W-1:0]   dvd_reg;
    logic [rtdct_pkg::DEN_W-1:0]   rem_reg;
    logic [rtdct_pkg::RAD_W-1:0]   rad_reg;
    logic [rtdct_pkg::SQR_W-1:0]   sq_rem_reg;
    logic [rtdct_pkg::ROOT_W-1:0]  root_reg;
    logic [rtdct_pkg::MAG_W-1:0]   mag_reg;
    logic                          neg_reg;
    logic [rtdct_pkg::CENT_W-1:0]  cent_reg;
    logic signed [rtdct_pkg::TEMP_W-1:0] temp_reg;
    logic [rtdct_pkg::CODE_W-1:0]  adc_code_reg;
    logic                          root_invalid_reg;

    // combinational helpers
    logic [2*rtdct_pkg::BYTE_W-1:0] word_new;
    logic [rtdct_pkg::DEN_W:0]      div_sh;
    logic [rtdct_pkg::DEN_W:0]      div_diff;
    logic                           div_ge;
    logic [rtdct_pkg::C_W-1:0]      v_diff;
    logic [rtdct_pkg::SQR_W+1:0]    sq_sh;
    logic [rtdct_pkg::SQR_W+1:0]    sq_trial;
    logic [rtdct_pkg::SQR_W+1:0]    sq_diff;
    logic                           sq_ge;
    logic [rtdct_pkg::MAG_W-1:0]    p_ext;
    logic [rtdct_pkg::MAG_W-1:0]    root_ext;
    logic [rtdct_pkg::CENT_W:0]     rnd_sum;
    logic [rtdct_pkg::TEMP_W-1:0]   cent_mag;

    assign held_msb_next = (msb_byte == rtdct_pkg::NO_REPLY) ? held_msb_reg : msb_byte;
    assign held_lsb_next = (lsb_byte == rtdct_pkg::NO_REPLY) ? held_lsb_reg : lsb_byte;
    assign word_new      = {held_msb_next, held_lsb_next};

    // restoring divider step
    assign div_sh   = {rem_reg, dvd_reg[rtdct_pkg::DVD_W-1]};
    assign div_diff = div_sh - {1'b0, den_reg};
    assign div_ge   = (div_sh >= {1'b0, den_reg});

    assign v_diff = rtdct_pkg::C_W'(rtdct_pkg::CVD_C) - dvd_reg[rtdct_pkg::C_W-1:0];

    // digit-by-digit square root step
    assign sq_sh    = {sq_rem_reg, rad_reg[rtdct_pkg::RAD_W-1 -: 2]};
    assign sq_trial = (rtdct_pkg::SQR_W + 2)'({root_reg, 2'b01});
    assign sq_diff  = sq_sh - sq_trial;
    assign sq_ge    = (sq_sh >= sq_trial);

    assign p_ext    = rtdct_pkg::MAG_W'(rtdct_pkg::CVD_P);
    assign root_ext = rtdct_pkg::MAG_W'(root_reg);

    assign rnd_sum  = {1'b0, cent_reg} + ROUND_HALF;
    assign cent_mag = rtdct_pkg::TEMP_W'(rnd_sum >> F);

    assign sts.invalid = invalid_reg;
    assign sts.qx_over = (dvd_reg > rtdct_pkg::DVD_W'(rtdct_pkg::CVD_C));

    assign temperature_centi = temp_reg;
    assign adc_code          = adc_code_reg;
    assign root_invalid      = root_invalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_msb_reg <= '0;
            held_lsb_reg <= '0;
        end
        else if (cmd.load)
        begin
            held_msb_reg <= held_msb_next;
            held_lsb_reg <= held_lsb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg    <= word_new[2*rtdct_pkg::BYTE_W-1:1];
            den_reg     <= rtdct_pkg::DEN_W'(rtdct_pkg::QX_DEN)
                           * rtdct_pkg::DEN_W'(nom_ohms);
            invalid_reg <= (nom_ohms == '0);
        end
        if (cmd.mul_code)
            p1_reg <= rtdct_pkg::P1_W'(code_reg) * rtdct_pkg::P1_W'(ref_ohms);
        if (cmd.mul_scale)
        begin
            dvd_reg <= {rtdct_pkg::PROD_W'(p1_reg) * rtdct_pkg::PROD_W'(rtdct_pkg::QX_NUM),
                        {F{1'b0}}};
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_diff[rtdct_pkg::DEN_W-1:0]
                              : div_sh[rtdct_pkg::DEN_W-1:0];
            dvd_reg <= {dvd_reg[rtdct_pkg::DVD_W-2:0], div_ge};
        end
        if (cmd.root_init)
        begin
            invalid_reg <= sts.qx_over;
            rad_reg     <= rtdct_pkg::RAD_W'({v_diff, {F{1'b0}}});
            sq_rem_reg  <= '0;
            root_reg    <= '0;
        end
        if (cmd.sqrt_step)
        begin
            rad_reg    <= {rad_reg[rtdct_pkg::RAD_W-3:0], 2'b00};
            sq_rem_reg <= sq_ge ? rtdct_pkg::SQR_W'(sq_diff) : rtdct_pkg::SQR_W'(sq_sh);
            root_reg   <= {root_reg[rtdct_pkg::ROOT_W-2:0], sq_ge};
        end
        if (cmd.mag)
        begin
            neg_reg <= (root_ext > p_ext);
            mag_reg <= (root_ext > p_ext) ? (root_ext - p_ext) : (p_ext - root_ext);
        end
        if (cmd.scale)
            cent_reg <= rtdct_pkg::CENT_W'(mag_reg) * rtdct_pkg::CENT_W'(rtdct_pkg::CENTI_SCALE);
        if (cmd.out_load)
        begin
            adc_code_reg     <= code_reg;
            root_invalid_reg <= invalid_reg;
            if (invalid_reg)
                temp_reg <= '0;
            else if (neg_reg)
                temp_reg <= -$signed(cent_mag);
            else
                temp_reg <= $signed(cent_mag);
        end
    end

endmodule

// ===== hw/rtl/rtd_code_to_temperature_unit.sv =====
// Top level of the RTD code to temperature unit: config registers, controller, datapath.
`timescale 1ns / 1ps

// Converts the MSB/LSB byte pair read from an RTD converter into a temperature
// in hundredths of a degree C (two's complement, rounded half away from zero).
// A byte of 0xFF means the converter did not answer and the previously held
// byte is reused; bit 0 of the LSB is the fault flag and is dropped, leaving
// a 15-bit code that is also echoed on adc_code. Resistance R = code*ref/32768
// is turned into temperature by inverting Callendar-Van Dusen (c = 0) with the
// quadratic formula in Q16 fixed point. If the discriminant would be negative,
// or the nominal resistance is zero, root_invalid is set and the temperature
// reads zero. Timing: one word at a time. A word accepted on sample_in passes
// through the multiply steps, the bit-serial divider for q*x, a range check,
// the bit-serial square root, and magnitude, scaling and rounding before its
// result is loaded into the output register; invalid results finish early
// (zero nominal resistance skips everything after the multiplies, a negative
// discriminant everything after the range check). sample_in is ready again
// the cycle after the result is loaded, even while that result still waits
// on result_out; no new word is taken before then. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at once and must only be made
// while the unit is idle; indexes other than 0 (reference resistor, reset
// 430) and 1 (nominal resistance, reset 100) are ignored.
module rtd_code_to_temperature_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rtdct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtdct_pkg::CFG_DATA_W-1:0]    cfg_data,
    rtdct_in_if.sink                            sample_in,
    rtdct_out_if.source                         result_out
);

    // configuration registers
    logic [rtdct_pkg::REF_W-1:0] ref_ohms_reg, ref_ohms_next;
    logic [rtdct_pkg::NOM_W-1:0] nom_ohms_reg, nom_ohms_next;

    rtdct_pkg::cmd_t cmd;
    rtdct_pkg::sts_t sts;

    always_comb
    begin
        ref_ohms_next = ref_ohms_reg;
        nom_ohms_next = nom_ohms_reg;
        if (cfg_we)
        begin
            // writes to unknown indexes fall through untouched
            priority if (cfg_index == rtdct_pkg::CFG_REF_IDX)
                ref_ohms_next = cfg_data[rtdct_pkg::REF_W-1:0];
            else if (cfg_index == rtdct_pkg::CFG_NOM_IDX)
                nom_ohms_next = cfg_data[rtdct_pkg::NOM_W-1:0];
            else
                ref_ohms_next = ref_ohms_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_ohms_reg <= rtdct_pkg::REF_W'(430);
            nom_ohms_reg <= rtdct_pkg::NOM_W'(100);
        end
        else
        begin
            ref_ohms_reg <= ref_ohms_next;
            nom_ohms_reg <= nom_ohms_next;
        end
    end

    // sequencing: accept, multiply, divide, root, scale, hand off
    rtdct_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic and the output word register
    rtdct_dp u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .msb_byte          (sample_in.msb_byte),
        .lsb_byte          (sample_in.lsb_byte),
        .ref_ohms          (ref_ohms_reg),
        .nom_ohms          (nom_ohms_reg),
        .temperature_centi (result_out.temperature_centi),
        .adc_code          (result_out.adc_code),
        .root_invalid      (result_out.root_invalid)
    );

endmodule
